// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the core rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/bec_pkg.sv -----
// ---------------------------------------------------------------------------
// bec_pkg
// shared types, constants and code tables of the byte escape codec
// ---------------------------------------------------------------------------
package bec_pkg;

    localparam int unsigned CMD_DEPTH = 2;
    localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam logic [7:0]  BACKSLASH     = 8'h5C;
    localparam logic [15:0] CAPACITY_INIT = 16'd1024;

    typedef enum logic [1:0] {
        CFG_DIRECTION = 2'd0,
        CFG_PAIR_PASS = 2'd1,
        CFG_CAPACITY  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_NORMAL   = 2'd0,
        PH_FOLLOW   = 2'd1,
        PH_AFTER_BS = 2'd2
    } t_phase;

    // one front-end decision: up to two bytes, or a bare end marker
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic       two;
        logic       has_byte;
        logic       last;
        logic       trunc;
    } t_cmd;

    function automatic logic [7:0] esc_code(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h0A:   r = 8'h6E;
            8'h2C:   r = 8'h63;
            8'h7C:   r = 8'h7A;
            8'h5C:   r = 8'h79;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] unesc_code(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h6E:   r = 8'h0A;
            8'h63:   r = 8'h2C;
            8'h7A:   r = 8'h7C;
            8'h79:   r = 8'h5C;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/bec_cmd_fifo.sv -----
// ---------------------------------------------------------------------------
// bec_cmd_fifo
// short command queue between the front and back ends
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bec_cmd_fifo
    import bec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr;
    logic [CMD_PTR_W-1:0] r_rd;
    logic [CMD_CNT_W-1:0] r_count;
    logic [CMD_PTR_W-1:0] n_wr;
    logic [CMD_PTR_W-1:0] n_rd;
    logic [CMD_CNT_W-1:0] n_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CMD_CNT_W'(CMD_DEPTH), "queue overfilled")
    `ASSERT_SAME(a_ptr_gap, i_clk, i_rst_n, (r_count == '0) || o_full, r_wr == r_rd, "pointers disagree with count")

endmodule

// ----- rtl/core/bec_front.sv -----
// ---------------------------------------------------------------------------
// bec_front
// classifies each source byte, tracks string state and issues commands
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bec_front
    import bec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_direction,
    input  logic        i_pair_pass,
    input  logic [15:0] i_capacity,
    output t_cmd        o_cmd,
    output logic        o_cmd_valid
);

    t_phase      r_phase;
    logic [15:0] r_count;
    logic        r_stopped;
    t_phase      n_phase;
    logic [15:0] n_count;
    logic        n_stopped;
    logic [1:0]  nb;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  code;
    logic [16:0] cnt1;
    logic [16:0] cnt2;
    logic [16:0] cap;

    assign code = esc_code(i_in_byte);
    assign cnt1 = {1'b0, r_count} + 17'd1;
    assign cnt2 = {1'b0, r_count} + 17'd2;
    assign cap  = {1'b0, i_capacity};

    always_comb begin
        n_phase   = r_phase;
        n_stopped = r_stopped;
        nb        = 2'd0;
        b0        = 8'h00;
        b1        = 8'h00;
        if (!r_stopped) begin
            case (r_phase)
                PH_FOLLOW: begin
                    n_phase = PH_NORMAL;
                    if (!i_direction && (cnt1 >= cap)) begin
                        n_stopped = 1'b1;
                    end else begin
                        nb = 2'd1;
                        b0 = i_in_byte;
                    end
                end
                PH_AFTER_BS: begin
                    n_phase = PH_NORMAL;
                    nb      = 2'd1;
                    b0      = unesc_code(i_in_byte);
                end
                default: begin
                    if (!i_direction) begin
                        if (cnt1 >= cap) begin
                            n_stopped = 1'b1;
                        end else if (i_pair_pass && i_in_byte[7]) begin
                            if (cnt2 >= cap) begin
                                n_stopped = 1'b1;
                            end else begin
                                nb      = 2'd1;
                                b0      = i_in_byte;
                                n_phase = PH_FOLLOW;
                            end
                        end else if (code != 8'h00) begin
                            if (cnt2 >= cap) begin
                                n_stopped = 1'b1;
                            end else begin
                                nb = 2'd2;
                                b0 = BACKSLASH;
                                b1 = code;
                            end
                        end else begin
                            nb = 2'd1;
                            b0 = i_in_byte;
                        end
                    end else begin
                        if (i_pair_pass && i_in_byte[7]) begin
                            nb      = 2'd1;
                            b0      = i_in_byte;
                            n_phase = PH_FOLLOW;
                        end else if (i_in_byte == BACKSLASH) begin
                            n_phase = PH_AFTER_BS;
                        end else begin
                            nb = 2'd1;
                            b0 = i_in_byte;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        if (!i_direction) begin
            n_count = r_count + 16'(nb);
        end
        if (i_in_last) begin
            n_count = '0;
        end
    end

    // truncation is only ever reported on a bare end marker
    always_comb begin
        o_cmd.b0       = b0;
        o_cmd.b1       = b1;
        o_cmd.two      = (nb == 2'd2);
        o_cmd.has_byte = (nb != 2'd0);
        o_cmd.last     = i_in_last;
        o_cmd.trunc    = i_in_last && (nb == 2'd0) && n_stopped;
        o_cmd_valid    = (nb != 2'd0) || i_in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_NORMAL;
            r_count   <= '0;
            r_stopped <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= i_in_last ? PH_NORMAL : n_phase;
            r_count   <= n_count;
            r_stopped <= i_in_last ? 1'b0 : n_stopped;
        end
    end

    `ASSERT_SAME(a_stop_normal, i_clk, i_rst_n, r_stopped, r_phase == PH_NORMAL, "stopped with pending phase")
    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_accept && i_in_last, (r_count == '0) && !r_stopped && (r_phase == PH_NORMAL), "string state not cleared")

endmodule

// ----- rtl/core/bec_back.sv -----
// ---------------------------------------------------------------------------
// bec_back
// expands queued commands into single result bytes on the output register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bec_back
    import bec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_empty,
    output logic       o_cmd_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_out_last,
    output logic       o_truncated
);

    t_cmd r_cmd;
    logic r_valid;
    logic r_sel;
    logic n_valid;
    logic n_sel;
    logic done;
    logic load;

    // current request is finished once its final byte is taken
    assign done      = r_valid && pop && (r_sel || !r_cmd.two);
    assign load      = !i_cmd_empty && (!r_valid || done);
    assign o_cmd_pop = load;

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        if (load) begin
            n_valid = 1'b1;
            n_sel   = 1'b0;
        end else if (done) begin
            n_valid = 1'b0;
            n_sel   = 1'b0;
        end else if (r_valid && pop) begin
            n_sel = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

    assign empty       = !r_valid;
    assign o_out_byte  = r_sel ? r_cmd.b1 : r_cmd.b0;
    assign o_has_byte  = r_sel || r_cmd.has_byte;
    assign o_out_last  = r_cmd.last && (r_sel || !r_cmd.two);
    assign o_truncated = r_cmd.trunc;

    `ASSERT_SAME(a_sel_pair, i_clk, i_rst_n, r_sel, r_valid && r_cmd.two, "second byte without pair")
    `ASSERT_NEXT(a_sel_advance, i_clk, i_rst_n, r_valid && r_cmd.two && !r_sel && pop, r_sel && r_valid, "pair did not advance")

endmodule

// ----- rtl/core/byte_escape_codec.sv -----
// ---------------------------------------------------------------------------
// byte_escape_codec
// streaming backslash escape / unescape of a byte string with capacity limit
// ---------------------------------------------------------------------------
// The block takes one source byte per cycle on push while full is low and
// returns result bytes on a queue-style output (empty/pop), one per cycle.
// A byte that escapes into a backslash pair gives two results, so a string
// of such bytes fills the command queue and holds the input side off with full.
// The limit is the single output register, which hands out one result byte
// per cycle while pop is high; a two-entry command queue lets the input
// side run ahead of it. A result passes through the command queue and then
// the output register before it shows on the output and can be popped.
// Configuration (index 0 direction, 1 pair passthrough, 2 capacity) may only
// be written between requests, while no result is outstanding.

module byte_escape_codec
    import bec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_has_byte,
    output logic        o_out_last,
    output logic        o_truncated
);

    logic        r_direction;
    logic        r_pair_pass;
    logic [15:0] r_capacity;
    logic        accept;
    t_cmd        front_cmd;
    logic        front_cmd_valid;
    t_cmd        head_cmd;
    logic        cmd_empty;
    logic        cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_pair_pass <= 1'b1;
            r_capacity  <= CAPACITY_INIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIRECTION: r_direction <= i_cfg_data[0];
                CFG_PAIR_PASS: r_pair_pass <= i_cfg_data[0];
                CFG_CAPACITY:  r_capacity  <= i_cfg_data;
                default:       r_capacity  <= r_capacity;
            endcase
        end
    end

    assign accept = push && !full;

    bec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .i_direction (r_direction),
        .i_pair_pass (r_pair_pass),
        .i_capacity  (r_capacity),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_cmd_valid)
    );

    bec_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && front_cmd_valid),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_cmd   (head_cmd),
        .o_empty (cmd_empty)
    );

    bec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .o_out_byte  (o_out_byte),
        .o_has_byte  (o_has_byte),
        .o_out_last  (o_out_last),
        .o_truncated (o_truncated)
    );

endmodule
